@@ rtl/conv2d_layer_output_defines.svh @@
// assertion macros for the conv2d layer output block
// used by the checker module only
`ifndef CONV2D_LAYER_OUTPUT_DEFINES_SVH
`define CONV2D_LAYER_OUTPUT_DEFINES_SVH
// implication checked at every clock edge outside reset
`define C2D_ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// implication into the next cycle
`define C2D_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

@@ rtl/c2d_pkg.sv @@
// shared types and constants for the conv2d layer output block
// no dependencies
`timescale 1ns / 1ps
package c2d_pkg;
  localparam int MAP_SIZE_D   = 32;
  localparam int MAX_KERNEL_D = 5;
  localparam int MAX_IN_CH_D  = 32;
  localparam int MAX_OUT_CH_D = 64;

  localparam logic [1:0] OP_WEIGHT  = 2'd0;
  localparam logic [1:0] OP_BIAS    = 2'd1;
  localparam logic [1:0] OP_FEATURE = 2'd2;
  localparam logic [1:0] OP_COMPUTE = 2'd3;

  localparam logic [1:0] REG_STRIDE = 2'd0;
  localparam logic [1:0] REG_KERNEL = 2'd1;
  localparam logic [1:0] REG_NCH    = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic [5:0]         out_channel;
    logic [4:0]         in_channel;
    logic [4:0]         row;
    logic [4:0]         col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] conv_sum;
    logic               status;
  } out_item_t;

  // classified command passed from front to back
  typedef enum logic [1:0] {
    CMD_WEIGHT, CMD_BIAS, CMD_FEATURE, CMD_COMPUTE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic               bad;      // write dropped or compute refused
    logic [5:0]         out_channel;
    logic [4:0]         in_channel;
    logic [4:0]         row;
    logic [4:0]         col;
    logic signed [31:0] value;    // already saturated for weight/feature
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_BIAS, ST_RUN, ST_DRAIN, ST_DONE
  } back_state_t;

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    if (v > 32'sd32767) return 16'sh7fff;
    if (v < -32'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction
endpackage

@@ rtl/conv2d_layer_output.sv @@
// conv2d layer output: one output element per compute item, stores filled by write items
// compute runs ST_BIAS, ST_RUN and ST_DRAIN (ST_RUN skipped with no channels, all if refused);
// one multiply-accumulate per cycle, set by the single read port of each store
// write items are stored as they are popped; the back end handles one item at a time
// result stays registered until taken; rst synchronously clears control, stores undefined
// depends on c2d_pkg, c2d_front, c2d_fifo, c2d_back
`timescale 1ns / 1ps
module conv2d_layer_output import c2d_pkg::*; #(
  parameter int MAP_SIZE   = MAP_SIZE_D,
  parameter int MAX_KERNEL = MAX_KERNEL_D,
  parameter int MAX_IN_CH  = MAX_IN_CH_D,
  parameter int MAX_OUT_CH = MAX_OUT_CH_D
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  logic [2:0] stride, ksize;
  logic [5:0] nch;
  cmd_t       fcmd, qcmd;
  logic       fpush, qpop, qne, qfull;

  assign cfg_ready = 1'b1;
  assign in_stall  = qfull;

  always_ff @(posedge clk) begin
    if (rst) begin
      stride <= 3'd1;
      ksize  <= 3'd5;
      nch    <= 6'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STRIDE: stride <= cfg_data[2:0];
        REG_KERNEL: ksize  <= cfg_data[2:0];
        REG_NCH:    nch    <= cfg_data[5:0];
        default:    ;
      endcase
    end
  end

  c2d_front #(.MAP_SIZE(MAP_SIZE), .MAX_KERNEL(MAX_KERNEL), .MAX_IN_CH(MAX_IN_CH),
              .MAX_OUT_CH(MAX_OUT_CH)) u_front (
    .clk, .rst, .item(in_data), .item_ok(in_valid && !in_stall),
    .stride, .ksize(ksize == 3'd0 ? 3'd1 :
                    (32'(ksize) > MAX_KERNEL ? 3'(MAX_KERNEL) : ksize)),
    .cmd(fcmd), .cmd_push(fpush)
  );

  c2d_fifo u_fifo (
    .clk, .rst, .push(fpush), .din(fcmd), .pop(qpop), .dout(qcmd),
    .not_empty(qne), .almost_full(qfull)
  );

  c2d_back #(.MAP_SIZE(MAP_SIZE), .MAX_KERNEL(MAX_KERNEL), .MAX_IN_CH(MAX_IN_CH),
             .MAX_OUT_CH(MAX_OUT_CH)) u_back (
    .clk, .rst, .cmd(qcmd), .cmd_valid(qne), .cmd_pop(qpop), .ksize, .nch,
    .result(out_data), .result_valid(out_valid), .result_stall(out_stall)
  );
endmodule

@@ rtl/c2d_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module c2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/c2d_front.sv @@
// front end: accepts items, checks ranges, saturates and pushes commands
// depends on c2d_pkg
`timescale 1ns / 1ps
module c2d_front import c2d_pkg::*; #(
  parameter int MAP_SIZE   = MAP_SIZE_D,
  parameter int MAX_KERNEL = MAX_KERNEL_D,
  parameter int MAX_IN_CH  = MAX_IN_CH_D,
  parameter int MAX_OUT_CH = MAX_OUT_CH_D
) (
  input  logic     clk,
  input  logic     rst,
  input  in_item_t item,
  input  logic     item_ok,
  input  logic [2:0] stride,
  input  logic [2:0] ksize,
  output cmd_t     cmd,
  output logic     cmd_push
);
  logic [7:0] r0, c0;
  logic [8:0] rend, cend;
  logic       bad;

  always_comb begin
    r0 = 8'(item.row * stride);
    c0 = 8'(item.col * stride);
    rend = 9'(item.row * stride) + 9'(ksize);
    cend = 9'(item.col * stride) + 9'(ksize);
    bad = 1'b0;
    unique case (item.op)
      OP_WEIGHT:  bad = (32'(item.out_channel) >= MAX_OUT_CH) ||
                        (32'(item.in_channel) >= MAX_IN_CH) ||
                        (32'(item.row) >= MAX_KERNEL) || (32'(item.col) >= MAX_KERNEL);
      OP_BIAS:    bad = 32'(item.out_channel) >= MAX_OUT_CH;
      OP_FEATURE: bad = (32'(item.in_channel) >= MAX_IN_CH) ||
                        (32'(item.row) >= MAP_SIZE) || (32'(item.col) >= MAP_SIZE);
      OP_COMPUTE: bad = (32'(item.out_channel) >= MAX_OUT_CH) ||
                        (32'(rend) > MAP_SIZE) || (32'(cend) > MAP_SIZE);
      default:    bad = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_push <= 1'b0;
    end else begin
      cmd_push <= item_ok;
    end
    if (item_ok) begin
      cmd.kind        <= cmd_kind_t'(item.op);
      cmd.bad         <= bad;
      cmd.out_channel <= item.out_channel;
      cmd.in_channel  <= item.in_channel;
      // compute carries its window origin in row/col (low five bits, upper bits checked above)
      cmd.row         <= (item.op == OP_COMPUTE) ? r0[4:0] : item.row;
      cmd.col         <= (item.op == OP_COMPUTE) ? c0[4:0] : item.col;
      cmd.value       <= (item.op == OP_BIAS) ? item.value : 32'(sat16(item.value));
    end
  end
endmodule

@@ rtl/c2d_fifo.sv @@
// short command queue between front and back
// depends on c2d_pkg
`timescale 1ns / 1ps
module c2d_fifo import c2d_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  input  logic pop,
  output cmd_t dout,
  output logic not_empty,
  output logic almost_full
);
  cmd_t       slots [4];
  logic [1:0] wp, rp;
  logic [2:0] count;

  assign dout        = slots[rp];
  assign not_empty   = count != 3'd0;
  // front has one register in flight, so stop at two
  assign almost_full = count >= 3'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (pop) rp <= rp + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
    if (push) slots[wp] <= din;
  end
endmodule

@@ rtl/c2d_back.sv @@
// back end: owns the stores, runs the multiply-accumulate sequence
// depends on c2d_pkg and c2d_ram
`timescale 1ns / 1ps
module c2d_back import c2d_pkg::*; #(
  parameter int MAP_SIZE   = MAP_SIZE_D,
  parameter int MAX_KERNEL = MAX_KERNEL_D,
  parameter int MAX_IN_CH  = MAX_IN_CH_D,
  parameter int MAX_OUT_CH = MAX_OUT_CH_D
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  logic       cmd_valid,
  output logic       cmd_pop,
  input  logic [2:0] ksize,
  input  logic [5:0] nch,
  output out_item_t  result,
  output logic       result_valid,
  input  logic       result_stall
);
  localparam int WDEPTH = MAX_OUT_CH * MAX_IN_CH * MAX_KERNEL * MAX_KERNEL;
  localparam int FDEPTH = MAX_IN_CH * MAP_SIZE * MAP_SIZE;
  localparam int WAW = $clog2(WDEPTH);
  localparam int FAW = $clog2(FDEPTH);
  localparam int BAW = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
  localparam int KW  = $clog2(MAX_KERNEL + 1);
  localparam int CW  = $clog2(MAX_IN_CH + 1);

  back_state_t state, state_next;
  cmd_t        job;
  logic [KW-1:0] kk, ti, tj;
  logic [CW-1:0] nn, m;
  logic [47:0]   acc;
  logic          mac_v1, mac_v2;
  logic signed [31:0] prod;

  logic [WAW-1:0] w_addr;
  logic [FAW-1:0] f_addr;
  logic [15:0]    w_q, f_q;
  logic [31:0]    b_q;
  logic           is_w, is_f, is_b, wr;

  assign wr   = cmd_valid && (state == ST_IDLE) && !cmd.bad;
  assign is_w = wr && (cmd.kind == CMD_WEIGHT);
  assign is_b = wr && (cmd.kind == CMD_BIAS);
  assign is_f = wr && (cmd.kind == CMD_FEATURE);

  always_comb begin
    if (is_w) begin
      w_addr = WAW'(((32'(cmd.out_channel) * MAX_IN_CH + 32'(cmd.in_channel)) * MAX_KERNEL
               + 32'(cmd.row)) * MAX_KERNEL + 32'(cmd.col));
      f_addr = FAW'(((32'(cmd.in_channel) * MAP_SIZE + 32'(cmd.row)) * MAP_SIZE)
               + 32'(cmd.col));
    end else begin
      w_addr = WAW'(((32'(job.out_channel) * MAX_IN_CH + 32'(m)) * MAX_KERNEL + 32'(ti))
               * MAX_KERNEL + 32'(tj));
      f_addr = FAW'((32'(m) * MAP_SIZE + 32'(job.row) + 32'(ti)) * MAP_SIZE
               + 32'(job.col) + 32'(tj));
    end
    if (is_f)
      f_addr = FAW'(((32'(cmd.in_channel) * MAP_SIZE + 32'(cmd.row)) * MAP_SIZE)
               + 32'(cmd.col));
  end

  c2d_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_wram (
    .clk, .we(is_w), .waddr(w_addr), .wdata(cmd.value[15:0]), .raddr(w_addr), .rdata(w_q)
  );
  c2d_ram #(.WIDTH(16), .DEPTH(FDEPTH)) u_fram (
    .clk, .we(is_f), .waddr(f_addr), .wdata(cmd.value[15:0]), .raddr(f_addr), .rdata(f_q)
  );
  // bias is read while the compute item is popped so it is ready in ST_BIAS
  c2d_ram #(.WIDTH(32), .DEPTH(1 << BAW)) u_bram (
    .clk, .we(is_b), .waddr(BAW'(cmd.out_channel)), .wdata(cmd.value),
    .raddr(BAW'((state == ST_IDLE) ? cmd.out_channel : job.out_channel)), .rdata(b_q)
  );

  logic last_tap;
  assign last_tap = (tj == kk - KW'(1)) && (ti == kk - KW'(1)) && (m == nn - CW'(1));

  always_comb begin
    state_next = state;
    cmd_pop = 1'b0;
    unique case (state)
      ST_IDLE: if (cmd_valid) begin
        cmd_pop = 1'b1;
        if (cmd.kind == CMD_COMPUTE) state_next = cmd.bad ? ST_DONE : ST_BIAS;
      end
      ST_BIAS:  state_next = (nn == '0) ? ST_DRAIN : ST_RUN;
      ST_RUN:   if (last_tap) state_next = ST_DRAIN;
      ST_DRAIN: if (!mac_v1 && !mac_v2) state_next = ST_DONE;
      ST_DONE:  if (!result_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      mac_v1 <= 1'b0;
      mac_v2 <= 1'b0;
    end else begin
      state  <= state_next;
      mac_v1 <= (state == ST_RUN);
      mac_v2 <= mac_v1;
    end
    if (state == ST_IDLE && cmd_valid) begin
      job <= cmd;
      kk  <= (ksize == 3'd0) ? KW'(1) :
             (32'(ksize) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(ksize);
      nn  <= (32'(nch) > MAX_IN_CH) ? CW'(MAX_IN_CH) : CW'(nch);
      ti <= '0;
      tj <= '0;
      m  <= '0;
    end
    if (state == ST_BIAS) acc <= 48'(signed'(b_q));
    if (state == ST_RUN) begin
      if (tj == kk - KW'(1)) begin
        tj <= '0;
        if (ti == kk - KW'(1)) begin
          ti <= '0;
          m  <= m + CW'(1);
        end else ti <= ti + KW'(1);
      end else tj <= tj + KW'(1);
    end
    // ram read data is registered, then the product in prod, then the sum in acc
    if (mac_v1) prod <= signed'(f_q) * signed'(w_q);
    if (mac_v2) acc <= acc + 48'(prod);
  end

  assign result_valid    = (state == ST_DONE);
  assign result.conv_sum = job.bad ? 48'sd0 : acc;
  assign result.status   = job.bad;
endmodule

@@ rtl/c2d_checker.sv @@
// port-level checks for conv2d_layer_output, bound to the top level
// depends on c2d_pkg and conv2d_layer_output_defines.svh
`timescale 1ns / 1ps
`include "conv2d_layer_output_defines.svh"
module c2d_checker import c2d_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data,
  input logic      cfg_ready
);
  `C2D_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "result dropped while stalled")
  `C2D_ASSERT_IMPL(a_refused_zero, clk, rst, out_valid && out_data.status, out_data.conv_sum == 48'sd0, "refused item carries a sum")
  `C2D_ASSERT_NEXT(a_one_result, clk, rst, out_valid && !out_stall, !out_valid, "result repeated")
  `C2D_ASSERT_IMPL(a_cfg_ready, clk, rst, 1'b1, cfg_ready, "config port not ready")
endmodule

bind conv2d_layer_output c2d_checker u_checker (
  .clk, .rst, .out_valid, .out_stall, .out_data, .cfg_ready
);

@@ tb/conv2d_layer_output_tb.sv @@
// testbench for conv2d_layer_output: fills the weight, bias and feature stores,
// then checks every compute result against an in-bench predictor; depends on c2d_pkg
`timescale 1ns / 1ps
module conv2d_layer_output_tb;
  import c2d_pkg::*;

  localparam int W_DEPTH = MAX_OUT_CH_D * MAX_IN_CH_D * MAX_KERNEL_D * MAX_KERNEL_D;
  localparam int F_DEPTH = MAX_IN_CH_D * MAP_SIZE_D * MAP_SIZE_D;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEM_TARGET = 750;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_STRIDE;
  logic [31:0] cfg_data = '0;

  conv2d_layer_output u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor copy of the block's state
  logic signed [15:0] wgt_mem [0:W_DEPTH-1];
  bit                 wgt_set [0:W_DEPTH-1];
  logic signed [15:0] feat_mem [0:F_DEPTH-1];
  bit                 feat_set [0:F_DEPTH-1];
  logic signed [31:0] bias_mem [0:MAX_OUT_CH_D-1];
  bit                 bias_set [0:MAX_OUT_CH_D-1];
  logic [2:0] cur_stride = 3'd1;
  logic [2:0] cur_kernel = 3'd5;
  logic [5:0] cur_nch    = 6'd1;

  out_item_t expected_q[$];
  int unsigned items_sent = 0;
  int unsigned sums_checked = 0;
  int unsigned windows_refused = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit quiet = 1'b0;
  int unsigned stall_left = 0;

  function automatic int unsigned w_at(int unsigned oc, int unsigned ic, int unsigned r,
                                       int unsigned c);
    return ((oc * MAX_IN_CH_D + ic) * MAX_KERNEL_D + r) * MAX_KERNEL_D + c;
  endfunction

  function automatic int unsigned f_at(int unsigned ic, int unsigned r, int unsigned c);
    return (ic * MAP_SIZE_D + r) * MAP_SIZE_D + c;
  endfunction

  function automatic logic signed [15:0] clamp16(logic signed [31:0] v);
    if (v > 32'sd32767) return 16'sh7fff;
    else if (v < -32'sd32768) return 16'sh8000;
    else return v[15:0];
  endfunction

  function automatic int unsigned eff_kernel();
    if (cur_kernel == 0) return 1;
    else if (cur_kernel > MAX_KERNEL_D) return MAX_KERNEL_D;
    else return 32'(cur_kernel);
  endfunction

  function automatic int unsigned eff_nch();
    return (cur_nch > MAX_IN_CH_D) ? MAX_IN_CH_D : 32'(cur_nch);
  endfunction

  function automatic logic [31:0] rand_value();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return $urandom();
    else return $urandom_range(0, 65535) - 32768;
  endfunction

  // updates stores and queues the expected result for one accepted item
  task automatic predict_item(in_item_t it);
    int unsigned k, n, r0, c0;
    logic signed [63:0] acc;
    out_item_t res;
    case (it.op)
      OP_WEIGHT: begin
        if (it.row < MAX_KERNEL_D && it.col < MAX_KERNEL_D) begin
          wgt_mem[w_at(it.out_channel, it.in_channel, it.row, it.col)] = clamp16(it.value);
          wgt_set[w_at(it.out_channel, it.in_channel, it.row, it.col)] = 1'b1;
        end
      end
      OP_BIAS: begin
        bias_mem[it.out_channel] = it.value;
        bias_set[it.out_channel] = 1'b1;
      end
      OP_FEATURE: begin
        feat_mem[f_at(it.in_channel, it.row, it.col)] = clamp16(it.value);
        feat_set[f_at(it.in_channel, it.row, it.col)] = 1'b1;
      end
      default: begin
        k = eff_kernel();
        n = eff_nch();
        r0 = 32'(it.row) * 32'(cur_stride);
        c0 = 32'(it.col) * 32'(cur_stride);
        if (r0 + k > MAP_SIZE_D || c0 + k > MAP_SIZE_D) begin
          res.conv_sum = '0;
          res.status = 1'b1;
        end else begin
          acc = 64'(bias_mem[it.out_channel]);
          for (int m = 0; m < n; m++)
            for (int i = 0; i < k; i++)
              for (int j = 0; j < k; j++)
                acc += 64'(feat_mem[f_at(m, r0 + i, c0 + j)]) *
                       64'(wgt_mem[w_at(it.out_channel, m, i, j)]);
          res.conv_sum = acc[47:0];
          res.status = 1'b0;
        end
        expected_q.push_back(res);
      end
    endcase
  endtask

  // drives one item, holds it until accepted, then an optional gap
  task automatic send_item(in_item_t it);
    int unsigned pick, gap;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(it);
    items_sent++;
    pick = $urandom_range(0, 99);
    if (quiet || pick < 65) gap = 0;
    else if (pick < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 60);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_fields(logic [1:0] op, int unsigned oc, int unsigned ic,
                             int unsigned r, int unsigned c, logic [31:0] v);
    in_item_t it;
    it.op = op;
    it.out_channel = 6'(oc);
    it.in_channel = 5'(ic);
    it.row = 5'(r);
    it.col = 5'(c);
    it.value = v;
    send_item(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    // trailing write items may still be in the pipe
    repeat (30) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_STRIDE: cur_stride = data[2:0];
      REG_KERNEL: cur_kernel = data[2:0];
      default: cur_nch = data[5:0];
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(int unsigned s, int unsigned k, int unsigned n);
    wait_drained();
    cfg_write(REG_STRIDE, s);
    cfg_write(REG_KERNEL, k);
    cfg_write(REG_NCH, n);
  endtask

  // writes every entry the window still lacks and rewrites some at random, then issues the compute item
  task automatic fill_and_compute(int unsigned oc, int unsigned r, int unsigned c);
    int unsigned k, n, r0, c0;
    k = eff_kernel();
    n = eff_nch();
    r0 = r * cur_stride;
    c0 = c * cur_stride;
    if (r0 + k <= MAP_SIZE_D && c0 + k <= MAP_SIZE_D) begin
      if (!bias_set[oc] || $urandom_range(0, 7) == 0)
        send_fields(OP_BIAS, oc, $urandom_range(0, 31), $urandom_range(0, 31),
                    $urandom_range(0, 31), $urandom());
      for (int m = 0; m < n; m++)
        for (int i = 0; i < k; i++)
          for (int j = 0; j < k; j++) begin
            if (!feat_set[f_at(m, r0 + i, c0 + j)] || $urandom_range(0, 15) == 0)
              send_fields(OP_FEATURE, $urandom_range(0, 63), m, r0 + i, c0 + j,
                          rand_value());
            if (!wgt_set[w_at(oc, m, i, j)] || $urandom_range(0, 15) == 0)
              send_fields(OP_WEIGHT, oc, m, i, j, rand_value());
          end
    end else begin
      windows_refused++;
    end
    send_fields(OP_COMPUTE, oc, $urandom_range(0, 31), r, c, $urandom());
  endtask

  task automatic report(string what, out_item_t got, out_item_t want);
    errors++;
    $display("mismatch %s: got sum %0d status %0d, want sum %0d status %0d",
             what, got.conv_sum, got.status, want.conv_sum, want.status);
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report("unexpected result", out_data, '0);
      end else begin
        want = expected_q.pop_front();
        sums_checked++;
        if (out_data.conv_sum !== want.conv_sum) report("conv_sum", out_data, want);
        if (out_data.status !== want.status) report("status", out_data, want);
      end
    end
  end

  // receiver back-pressure, mostly short bursts with an occasional long one
  always @(posedge clk) begin
    int unsigned pick;
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60) out_stall <= 1'b0;
      else begin
        out_stall <= 1'b1;
        stall_left <= (pick < 96) ? $urandom_range(0, 3) : $urandom_range(10, 80);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    // reset setting: stride 1, kernel 5, one channel
    send_fields(OP_WEIGHT, 63, 31, 7, 7, 32'h7fffffff);   // tap outside kernel, dropped
    send_fields(OP_WEIGHT, 0, 31, 31, 0, 32'h1234);       // dropped
    send_fields(OP_FEATURE, 0, 31, 31, 31, 32'h80000000);
    send_fields(OP_FEATURE, 63, 0, 31, 31, 32'h7fffffff);
    send_fields(OP_BIAS, 63, 0, 0, 0, 32'h80000000);
    send_fields(OP_BIAS, 0, 0, 0, 0, 32'h7fffffff);
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 5; j++) begin
        send_fields(OP_WEIGHT, 63, 0, i, j, (i + j) % 2 ? 32'h80000000 : 32'h7fffffff);
        send_fields(OP_FEATURE, 0, 0, 27 + i, 27 + j, (i * 5 + j) % 3 ? 32'h7fff : 32'hffff8000);
      end
    fill_and_compute(63, 27, 27);   // last valid position, saturated operands
    fill_and_compute(63, 28, 27);   // window leaves the map
    fill_and_compute(0, 31, 31);    // far corner, refused
    fill_and_compute(0, 0, 0);
  endtask

  task automatic test_random_phase(int unsigned s, int unsigned k, int unsigned n,
                                   int unsigned budget);
    int unsigned stop_at, pick, oc, rmax, r, c, kk;
    set_config(s, k, n);
    quiet = ($urandom_range(0, 3) == 0);
    stop_at = items_sent + budget;
    kk = eff_kernel();
    rmax = (cur_stride == 0) ? 31 : (MAP_SIZE_D - kk) / cur_stride;
    if (rmax > 31) rmax = 31;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick == 0) begin
        // hold off until every pending result is back
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
      end
      if (pick < 70) begin
        oc = (eff_nch() * kk * kk > 100) ? $urandom_range(0, 1) : $urandom_range(0, 63);
        if ($urandom_range(0, 9) == 0) begin
          r = $urandom_range(0, 31);
          c = $urandom_range(0, 31);
        end else begin
          r = $urandom_range(0, rmax);
          c = $urandom_range(0, rmax);
        end
        fill_and_compute(oc, r, c);
      end else if (pick < 80) begin
        send_fields(OP_WEIGHT, $urandom_range(0, 63), $urandom_range(0, 31),
                    $urandom_range(0, 7), $urandom_range(0, 7), rand_value());
      end else if (pick < 90) begin
        send_fields(OP_FEATURE, $urandom_range(0, 63), $urandom_range(0, 31),
                    $urandom_range(0, 31), $urandom_range(0, 31), rand_value());
      end else begin
        send_fields(OP_BIAS, $urandom_range(0, 63), $urandom_range(0, 31),
                    $urandom_range(0, 31), $urandom_range(0, 31), $urandom());
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phase(1, 5, 1, 80);
    test_random_phase(0, 1, 0, 60);      // bias only, origin window
    test_random_phase(2, 3, 4, 80);
    test_random_phase(7, 7, 1, 50);      // kernel clamps to the maximum
    test_random_phase(4, 1, 63, 40);     // channel count clamps to the maximum
    test_random_phase(3, 0, 2, 80);
    test_random_phase(1, 4, 5, ITEM_TARGET > items_sent ? ITEM_TARGET - items_sent : 40);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (900) @(posedge clk);
    if (expected_q.size() != 0) begin
      errors++;
      $display("%0d results never arrived", expected_q.size());
    end
    $display("sent %0d items over 7 settings, %0d results checked, %0d refused windows",
             items_sent, sums_checked, windows_refused);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
